// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication check: whenever ante holds, cons must hold in the same cycle
`define KWM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// invariant check: prop holds at every clock edge out of reset
`define KWM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

// ===== hw/rtl/kwm_pkg.sv =====
// ----------------------------------------------------------------------------
// kwm_pkg
// shared types and constants of the k-way merge block
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam int RUN_BITS = 6;
    localparam int CFG_BITS = 7;

    localparam logic MODE_ELEM = 1'b0;
    localparam logic MODE_END  = 1'b1;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_SCAN,
        ST_EMIT,
        ST_WAIT,
        ST_DONE
    } kwm_state_t;

    typedef struct packed {
        logic fill_wr;
        logic refill_wr;
        logic scan_start;
        logic scan_run;
        logic emit_load;
    } kwm_cmd_t;

    typedef struct packed {
        logic fill_ok;
        logic fill_last;
        logic refill_ok;
        logic scan_done;
        logic found;
        logic out_free;
    } kwm_sts_t;

endpackage

// ===== hw/rtl/kwm_ram.sv =====
// ----------------------------------------------------------------------------
// kwm_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module kwm_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/kwm_datapath.sv =====
// ----------------------------------------------------------------------------
// kwm_datapath
// head store, fill tracking, serial minimum scan and result register
// ----------------------------------------------------------------------------
module kwm_datapath
    import kwm_pkg::*;
#(
    parameter int MAX_RUNS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wen,
    input  logic [CFG_BITS-1:0]          cfg_wdata,
    input  logic                         in_mode,
    input  logic [RUN_BITS-1:0]          in_run,
    input  logic signed [VALUE_BITS-1:0] in_value,
    input  kwm_cmd_t                     cmd,
    output kwm_sts_t                     sts,
    input  logic                         out_tready,
    output logic                         out_tvalid,
    output logic signed [VALUE_BITS-1:0] value_res,
    output logic [RUN_BITS-1:0]          source_run,
    output logic                         done_res
);

    `include "assert_macros.svh"

    localparam int RUN_W = $clog2(MAX_RUNS);
    localparam int CNT_W = $clog2(MAX_RUNS + 1);
    localparam int CW    = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;
    localparam int ENT_W = VALUE_BITS + 1;

    logic [CNT_W-1:0]             n_reg, n_next;
    logic [CNT_W-1:0]             fill_cnt_reg, fill_cnt_next;
    logic [MAX_RUNS-1:0]          filled_reg, filled_next;
    logic [CNT_W-1:0]             iss_reg, iss_next;
    logic                         pend_reg, pend_next;
    logic                         found_reg, found_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         done_reg, done_next;
    logic [RUN_W-1:0]             pidx_reg, pidx_next;
    logic [RUN_W-1:0]             best_reg, best_next;
    logic signed [VALUE_BITS-1:0] best_val_reg, best_val_next;
    logic signed [VALUE_BITS-1:0] res_val_reg, res_val_next;
    logic [RUN_BITS-1:0]          res_src_reg, res_src_next;

    logic [RUN_W-1:0]             run_addr;
    logic                         run_in_range;
    logic                         ram_we;
    logic                         ram_re;
    logic [ENT_W-1:0]             ram_wdata;
    logic [ENT_W-1:0]             ram_rdata;
    logic                         rd_live;
    logic signed [VALUE_BITS-1:0] rd_val;

    assign run_addr     = RUN_W'(in_run);
    assign run_in_range = CW'(in_run) < CW'(n_reg);

    // entry holds the ended flag above the head value
    assign ram_we    = cmd.fill_wr || cmd.refill_wr;
    assign ram_wdata = {in_mode == MODE_END, in_value};
    assign ram_re    = cmd.scan_run && (iss_reg != n_reg);
    assign rd_live   = !ram_rdata[VALUE_BITS];
    assign rd_val    = $signed(ram_rdata[VALUE_BITS-1:0]);

    kwm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_RUNS)
    ) u_heads (
        .clk   (clk),
        .we    (ram_we),
        .waddr (run_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (iss_reg[RUN_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        n_next        = n_reg;
        fill_cnt_next = fill_cnt_reg;
        filled_next   = filled_reg;
        if (cfg_wen)
        begin
            // zero acts as one, oversized counts saturate
            if (cfg_wdata == '0)
            begin
                n_next = CNT_W'(1);
            end
            else if (32'(cfg_wdata) > MAX_RUNS)
            begin
                n_next = CNT_W'(MAX_RUNS);
            end
            else
            begin
                n_next = CNT_W'(cfg_wdata);
            end
            fill_cnt_next = '0;
            filled_next   = '0;
        end
        else if (cmd.fill_wr)
        begin
            fill_cnt_next         = fill_cnt_reg + 1'b1;
            filled_next[run_addr] = 1'b1;
        end
    end

    always_comb
    begin
        iss_next      = iss_reg;
        pend_next     = 1'b0;
        pidx_next     = pidx_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        best_val_next = best_val_reg;
        if (cmd.scan_start)
        begin
            iss_next   = '0;
            found_next = 1'b0;
        end
        else if (cmd.scan_run)
        begin
            if (iss_reg != n_reg)
            begin
                iss_next  = iss_reg + 1'b1;
                pend_next = 1'b1;
                pidx_next = iss_reg[RUN_W-1:0];
            end
            // strict less keeps the lowest index on ties
            if (pend_reg && rd_live && (!found_reg || rd_val < best_val_reg))
            begin
                found_next    = 1'b1;
                best_next     = pidx_reg;
                best_val_next = rd_val;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        done_next      = done_reg;
        res_val_next   = res_val_reg;
        res_src_next   = res_src_reg;
        if (cmd.emit_load)
        begin
            out_valid_next = 1'b1;
            done_next      = !found_reg;
            res_val_next   = found_reg ? best_val_reg : '0;
            res_src_next   = found_reg ? RUN_BITS'(best_reg) : '0;
        end
        else if (out_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= CNT_W'(1);
            fill_cnt_reg  <= '0;
            filled_reg    <= '0;
            iss_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            n_reg         <= n_next;
            fill_cnt_reg  <= fill_cnt_next;
            filled_reg    <= filled_next;
            iss_reg       <= iss_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg     <= pidx_next;
        best_reg     <= best_next;
        best_val_reg <= best_val_next;
        res_val_reg  <= res_val_next;
        res_src_reg  <= res_src_next;
    end

    assign sts.fill_ok   = run_in_range && !filled_reg[run_addr];
    assign sts.fill_last = CNT_W'(fill_cnt_reg + 1'b1) == n_reg;
    assign sts.refill_ok = CW'(in_run) == CW'(best_reg);
    assign sts.scan_done = (iss_reg == n_reg) && !pend_reg;
    assign sts.found     = found_reg;
    assign sts.out_free  = !out_valid_reg || out_tready;

    assign out_tvalid = out_valid_reg;
    assign value_res  = res_val_reg;
    assign source_run = res_src_reg;
    assign done_res   = done_reg;

    `KWM_ASSERT_ALWAYS(a_fill_count, $countones(filled_reg) == 32'(fill_cnt_reg), "fill count out of step with filled runs")
    `KWM_ASSERT_IMP(a_pend_after_read, pend_reg, $past(ram_re), "compare without a preceding head read")

endmodule

// ===== hw/rtl/kwm_ctrl.sv =====
// ----------------------------------------------------------------------------
// kwm_ctrl
// merge sequencer: initial fill, minimum scan, result hand-off, refill wait
// ----------------------------------------------------------------------------
module kwm_ctrl
    import kwm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_wen,
    input  logic     in_tvalid,
    output logic     in_tready,
    input  kwm_sts_t sts,
    output kwm_cmd_t cmd
);

    `include "assert_macros.svh"

    kwm_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_tready  = 1'b0;
        unique case (state_reg)
            ST_FILL:
            begin
                in_tready = 1'b1;
                if (in_tvalid && sts.fill_ok)
                begin
                    cmd.fill_wr = 1'b1;
                    if (sts.fill_last)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = sts.found ? ST_WAIT : ST_DONE;
                end
            end
            ST_WAIT:
            begin
                // only the run that just won may refill
                in_tready = 1'b1;
                if (in_tvalid && sts.refill_ok)
                begin
                    cmd.refill_wr  = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_DONE:
            begin
                in_tready = 1'b1;
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
        if (cfg_wen)
        begin
            state_next = ST_FILL;
        end
    end

    `KWM_ASSERT_IMP(a_wait_has_winner, state_reg == ST_WAIT, sts.found, "waiting for refill with no winning run")
    `KWM_ASSERT_IMP(a_done_no_winner, state_reg == ST_DONE, !sts.found, "done reached while a live head remains")

endmodule

// ===== hw/rtl/k_way_merge_of_sorted_runs.sv =====
// ----------------------------------------------------------------------------
// k_way_merge_of_sorted_runs
// merges up to run_count ascending runs of signed values into one stream
// ----------------------------------------------------------------------------
// Send one beat per run (element or end mark) to fill the heads; every result
// then names the run whose next beat is wanted, and the final result has tlast
// set. After the beat that completes the heads, the minimum search reads one
// head per cycle from the head ram through one comparator; the registered read
// data of the last head then reaches the comparator, the winner is handed to
// the output stage, and it is loaded into the output register once that is
// free. While a search runs, s_axis_tready is low. Beats for runs that are not
// awaiting refill are taken and dropped. Writing cfg_wdata restarts the merge
// at once; there is no clearing pass.
module k_way_merge_of_sorted_runs
    import kwm_pkg::*;
#(
    parameter int MAX_RUNS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // run, value
    input  logic [((RUN_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // mode
    input  logic                s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // value_res, source_run
    output logic [((RUN_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // done_res
    output logic                m_axis_tlast
);

    localparam int DATA_W = ((RUN_BITS + VALUE_BITS + 7) / 8) * 8;

    kwm_cmd_t                     cmd;
    kwm_sts_t                     sts;
    logic [RUN_BITS-1:0]          in_run;
    logic signed [VALUE_BITS-1:0] in_value;
    logic signed [VALUE_BITS-1:0] value_res;
    logic [RUN_BITS-1:0]          source_run;

    assign in_run   = s_axis_tdata[RUN_BITS-1:0];
    assign in_value = $signed(s_axis_tdata[RUN_BITS +: VALUE_BITS]);

    kwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    kwm_datapath #(
        .MAX_RUNS   (MAX_RUNS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .in_mode    (s_axis_tuser),
        .in_run     (in_run),
        .in_value   (in_value),
        .cmd        (cmd),
        .sts        (sts),
        .out_tready (m_axis_tready),
        .out_tvalid (m_axis_tvalid),
        .value_res  (value_res),
        .source_run (source_run),
        .done_res   (m_axis_tlast)
    );

    assign m_axis_tdata = DATA_W'({source_run, value_res});

endmodule
